>>> src/hybrid_reaction_propensity_core_defines.svh
// Assertion macros for the top-level RTL file of the propensity core.
`ifndef HYBRID_REACTION_PROPENSITY_CORE_DEFINES_SVH
`define HYBRID_REACTION_PROPENSITY_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, clocked on aclk, off during reset.
`define HRP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
// Next-cycle implication, clocked on aclk, off during reset.
`define HRP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define HRP_ASSERT(lbl, prop, msg)
`define HRP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> src/hrp_pkg.sv
// Types, widths and codes shared by the propensity core modules.
package hrp_pkg;

    localparam int DATA_W     = 32;
    localparam int COUNT_W    = 16;
    localparam int PROP_W     = 48;
    localparam int IDX_W      = 10;
    localparam int GRID_CFG_W = 7;
    localparam int CFG_IDX_W  = 4;
    localparam int PROD_W     = 64;
    localparam int S_TDATA_W  = 88;
    localparam int M_TDATA_W  = 336;

    typedef logic [DATA_W-1:0]  word_t;
    typedef logic [PROP_W-1:0]  prop_t;
    typedef logic [PROD_W-1:0]  prod_t;
    typedef logic [3:0]         op_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam prop_t MAX48 = '1;

    // register indexes of the configuration port
    localparam cfg_idx_t CFG_GRID      = 4'd0;
    localparam cfg_idx_t CFG_STEP      = 4'd1;
    localparam cfg_idx_t CFG_DENSITY   = 4'd2;
    localparam cfg_idx_t CFG_JUMP      = 4'd3;
    localparam cfg_idx_t CFG_PROD      = 4'd4;
    localparam cfg_idx_t CFG_DEGRADE   = 4'd5;
    localparam cfg_idx_t CFG_CONVERT   = 4'd6;
    localparam cfg_idx_t CFG_THRESHOLD = 4'd7;

    // multiply steps of the per-compartment sequence, in issue order
    localparam op_t OP_SUM_LO = 4'd0;
    localparam op_t OP_SUM_HI = 4'd1;
    localparam op_t OP_DIFF   = 4'd2;
    localparam op_t OP_PROD   = 4'd3;
    localparam op_t OP_NN     = 4'd4;
    localparam op_t OP_CONT   = 4'd5;
    localparam op_t OP_PAIR   = 4'd6;
    localparam op_t OP_T      = 4'd7;
    localparam op_t OP_DISC   = 4'd8;
    localparam op_t OP_MIX_LO = 4'd9;
    localparam op_t OP_MIX_HI = 4'd10;
    localparam op_t OP_LAST   = OP_MIX_HI;

    // compartment close event from the sample accumulator
    typedef struct packed {
        logic             close;
        logic             above;
        logic             is_end;
        logic [IDX_W-1:0] idx;
    } hrp_close_t;

endpackage

>>> src/hrp_accum.sv
// Sample accumulator: grid counter, mass sum, density check and compartment counter.
module hrp_accum import hrp_pkg::*; #(
    parameter int MAX_GRID         = 64,
    parameter int MAX_COMPARTMENTS = 1024,
    parameter int SUM_W            = 32 + $clog2(MAX_GRID)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  accept,
    input  word_t                 pde_value,
    input  logic                  domain_last,
    input  logic [GRID_CFG_W-1:0] grid_cfg,
    input  word_t                 density_limit,
    output hrp_close_t            close_info,
    output logic [SUM_W-1:0]      sum_total
);

    localparam int GC_W  = $clog2(MAX_GRID + 1);
    localparam int GW    = (GC_W > GRID_CFG_W) ? GC_W : GRID_CFG_W;
    localparam int CNT_W = $clog2(MAX_COMPARTMENTS);

    logic [GC_W-1:0]  grid_count_reg, grid_count_next;
    logic [SUM_W-1:0] mass_sum_reg, mass_sum_next;
    logic             all_above_reg, all_above_next;
    logic [CNT_W-1:0] comp_cnt_reg, comp_cnt_next;

    logic [GW-1:0]    grid_eff;
    logic [GW-1:0]    grid_inc;
    logic             sample_above;
    logic             closing;

    always_comb begin
        // zero acts as one, oversize clips to the maximum
        if (grid_cfg == '0) begin
            grid_eff = GW'(1);
        end else if (GW'(grid_cfg) > GW'(MAX_GRID)) begin
            grid_eff = GW'(MAX_GRID);
        end else begin
            grid_eff = GW'(grid_cfg);
        end
    end

    assign grid_inc     = GW'(grid_count_reg) + GW'(1);
    assign closing      = (grid_inc >= grid_eff);
    assign sample_above = (pde_value > density_limit);
    assign sum_total    = mass_sum_reg + SUM_W'(pde_value);

    assign close_info.close  = accept && closing;
    assign close_info.above  = all_above_reg && sample_above;
    assign close_info.is_end = (comp_cnt_reg == '0) || domain_last;
    assign close_info.idx    = IDX_W'(comp_cnt_reg);

    always_comb begin
        grid_count_next = grid_count_reg;
        mass_sum_next   = mass_sum_reg;
        all_above_next  = all_above_reg;
        comp_cnt_next   = comp_cnt_reg;
        if (accept) begin
            if (closing) begin
                grid_count_next = '0;
                mass_sum_next   = '0;
                all_above_next  = 1'b1;
                if (domain_last || comp_cnt_reg == CNT_W'(MAX_COMPARTMENTS - 1)) begin
                    comp_cnt_next = '0;
                end else begin
                    comp_cnt_next = comp_cnt_reg + CNT_W'(1);
                end
            end else begin
                grid_count_next = GC_W'(grid_inc);
                mass_sum_next   = sum_total;
                all_above_next  = all_above_reg && sample_above;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_count_reg <= '0;
            mass_sum_reg   <= '0;
            all_above_reg  <= 1'b1;
            comp_cnt_reg   <= '0;
        end else begin
            grid_count_reg <= grid_count_next;
            mass_sum_reg   <= mass_sum_next;
            all_above_reg  <= all_above_next;
            comp_cnt_reg   <= comp_cnt_next;
        end
    end

endmodule

>>> src/hrp_mul.sv
// Shared 32x32 unsigned multiplier with a registered product.
module hrp_mul import hrp_pkg::*; (
    input  logic  aclk,
    input  logic  en,
    input  word_t op_a,
    input  word_t op_b,
    output prod_t prod_reg
);

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
        end
    end

endmodule

>>> src/hybrid_reaction_propensity_core.sv
// Top level of the hybrid reaction propensity core: sequencer, result register.
//
//  channel | direction | handshake                  | content
//  s_      | in        | s_tvalid / s_tready        | one grid sample per request
//  m_      | out       | m_tvalid / m_tready        | one result per compartment
//  cfg_    | in        | cfg_valid / cfg_ready      | register index and data
//
// A sample that does not close its compartment is taken while the core stays idle and ready.
// A closing sample starts eleven steps on the shared multiplier, a drain state and a load
// state; the next request is taken after the load, once the result register is free.
// Reset (aresetn low, synchronous) clears counters, sequencer and valid flags.
// A stalled m_tready holds the sequencer in its load state with s_tready low.
`include "hybrid_reaction_propensity_core_defines.svh"

module hybrid_reaction_propensity_core import hrp_pkg::*; #(
    parameter int MAX_GRID         = 64,
    parameter int MAX_COMPARTMENTS = 1024
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // pde_value[31:0], ssa_count[47:32], comb_mass[79:48], mass_flag[80], zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tlast,   // domain_last
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // compartment_index[9:0], left_mass[41:10], block_above[42],
    // diffusion_propensity[90:43], production_propensity[138:91],
    // pair_degradation[186:139], mixed_degradation[234:187],
    // to_discrete[282:235], to_continuous[330:283], zero pad
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast,   // domain_end
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  cfg_idx_t             cfg_index,
    input  word_t                cfg_data
);

    localparam int SUM_W = 32 + $clog2(MAX_GRID);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_WAIT  = 2'd3;

    // configuration
    logic [GRID_CFG_W-1:0] grid_reg;
    word_t step_reg, density_reg, jump_reg, prod_rate_reg;
    word_t degrade_reg, convert_reg, threshold_reg;

    // input fields
    word_t                pde_value, comb_mass;
    logic [COUNT_W-1:0]   ssa_count;
    logic                 mass_flag;
    logic                 s_accept;

    hrp_close_t           close_info;
    logic [SUM_W-1:0]     sum_total;

    // captured compartment
    logic [SUM_W-1:0]     job_sum_reg;
    logic                 job_above_reg, job_end_reg, job_last_reg, job_flag_reg;
    logic [IDX_W-1:0]     job_idx_reg;
    logic [COUNT_W-1:0]   job_n_reg;
    word_t                job_cm_reg;

    // sequencer
    logic [1:0]           state_reg, state_next;
    op_t                  op_reg, op_next;
    logic                 post_vld_reg, post_vld_next;
    op_t                  post_op_reg, post_op_next;
    logic                 issue;
    word_t                mul_a, mul_b;
    prod_t                prod_reg;
    logic [PROD_W-1:0]    sum_ext;
    logic [COUNT_W-1:0]   n_minus_1;
    logic [PROD_W:0]      hi_sum;

    // working results
    prod_t                acc_reg;
    prod_t                t_reg;
    word_t                nn_reg;
    word_t                approx_reg;
    prop_t                diff_reg, prodp_reg, pair_reg, mixed_reg, disc_reg, cont_reg;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tlast_reg;
    logic                 out_load;

    assign pde_value = s_tdata[31:0];
    assign ssa_count = s_tdata[47:32];
    assign comb_mass = s_tdata[79:48];
    assign mass_flag = s_tdata[80];

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_reg      <= GRID_CFG_W'(4);
            step_reg      <= 32'h0001_0000;
            density_reg   <= 32'h0001_0000;
            jump_reg      <= '0;
            prod_rate_reg <= '0;
            degrade_reg   <= '0;
            convert_reg   <= '0;
            threshold_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_GRID:      grid_reg      <= cfg_data[GRID_CFG_W-1:0];
                CFG_STEP:      step_reg      <= cfg_data;
                CFG_DENSITY:   density_reg   <= cfg_data;
                CFG_JUMP:      jump_reg      <= cfg_data;
                CFG_PROD:      prod_rate_reg <= cfg_data;
                CFG_DEGRADE:   degrade_reg   <= cfg_data;
                CFG_CONVERT:   convert_reg   <= cfg_data;
                CFG_THRESHOLD: threshold_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    hrp_accum #(
        .MAX_GRID         (MAX_GRID),
        .MAX_COMPARTMENTS (MAX_COMPARTMENTS),
        .SUM_W            (SUM_W)
    ) u_accum (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (s_accept),
        .pde_value     (pde_value),
        .domain_last   (s_tlast),
        .grid_cfg      (grid_reg),
        .density_limit (density_reg),
        .close_info    (close_info),
        .sum_total     (sum_total)
    );

    // latch the closing sample
    always_ff @(posedge aclk) begin
        if (close_info.close) begin
            job_sum_reg   <= sum_total;
            job_above_reg <= close_info.above;
            job_end_reg   <= close_info.is_end;
            job_idx_reg   <= close_info.idx;
            job_last_reg  <= s_tlast;
            job_flag_reg  <= mass_flag;
            job_n_reg     <= ssa_count;
            job_cm_reg    <= comb_mass;
        end
    end

    assign out_load = (state_reg == ST_WAIT) && (!m_tvalid_reg || m_tready);
    assign issue    = (state_reg == ST_RUN);

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        post_vld_next = 1'b0;
        post_op_next  = post_op_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (close_info.close) begin
                    state_next = ST_RUN;
                    op_next    = OP_SUM_LO;
                end
            end
            ST_RUN: begin
                post_vld_next = 1'b1;
                post_op_next  = op_reg;
                if (op_reg == OP_LAST) begin
                    state_next = ST_DRAIN;
                end else begin
                    op_next = op_reg + op_t'(1);
                end
            end
            ST_DRAIN: state_next = ST_WAIT;
            ST_WAIT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            op_reg       <= OP_SUM_LO;
            post_vld_reg <= 1'b0;
            post_op_reg  <= OP_SUM_LO;
        end else begin
            state_reg    <= state_next;
            op_reg       <= op_next;
            post_vld_reg <= post_vld_next;
            post_op_reg  <= post_op_next;
        end
    end

    assign sum_ext   = PROD_W'(job_sum_reg);
    assign n_minus_1 = job_n_reg - COUNT_W'(1);

    always_comb begin
        unique case (op_reg)
            OP_SUM_LO: begin mul_a = sum_ext[31:0];  mul_b = step_reg; end
            OP_SUM_HI: begin mul_a = sum_ext[63:32]; mul_b = step_reg; end
            OP_DIFF:   begin mul_a = jump_reg;       mul_b = DATA_W'(job_n_reg); end
            OP_PROD:   begin mul_a = job_cm_reg;     mul_b = prod_rate_reg; end
            OP_NN:     begin mul_a = DATA_W'(job_n_reg); mul_b = DATA_W'(n_minus_1); end
            OP_CONT:   begin mul_a = convert_reg;    mul_b = DATA_W'(job_n_reg); end
            OP_PAIR:   begin mul_a = degrade_reg;    mul_b = nn_reg; end
            OP_T:      begin mul_a = degrade_reg;    mul_b = approx_reg; end
            OP_DISC:   begin mul_a = approx_reg;     mul_b = convert_reg; end
            OP_MIX_LO: begin mul_a = t_reg[31:0];    mul_b = DATA_W'(job_n_reg); end
            OP_MIX_HI: begin mul_a = t_reg[63:32];   mul_b = DATA_W'(job_n_reg); end
            default:   begin mul_a = '0;             mul_b = '0; end
        endcase
    end

    hrp_mul u_mul (
        .aclk     (aclk),
        .en       (issue),
        .op_a     (mul_a),
        .op_b     (mul_b),
        .prod_reg (prod_reg)
    );

    // upper half of a two-part product: high partial plus carry-in word
    assign hi_sum = (PROD_W + 1)'(prod_reg) + (PROD_W + 1)'(acc_reg[63:32]);

    always_ff @(posedge aclk) begin
        if (post_vld_reg) begin
            unique case (post_op_reg)
                OP_SUM_LO: acc_reg <= prod_reg;
                OP_SUM_HI: begin
                    if (hi_sum[PROD_W:16] != '0) begin
                        approx_reg <= '1;
                    end else begin
                        approx_reg <= {hi_sum[15:0], acc_reg[31:16]};
                    end
                end
                OP_DIFF: begin
                    if (job_end_reg) begin
                        diff_reg <= prod_reg[47:0];
                    end else if (prod_reg[47]) begin
                        diff_reg <= MAX48;
                    end else begin
                        diff_reg <= {prod_reg[46:0], 1'b0};
                    end
                end
                OP_PROD:   prodp_reg <= job_above_reg ? prod_reg[63:16] : '0;
                OP_NN:     nn_reg    <= prod_reg[31:0];
                OP_CONT:   cont_reg  <= (job_cm_reg >= threshold_reg) ? prod_reg[47:0] : '0;
                OP_PAIR:   pair_reg  <= (prod_reg[63:48] != '0) ? MAX48 : prod_reg[47:0];
                OP_T:      t_reg     <= prod_reg;
                OP_DISC: begin
                    disc_reg <= (job_cm_reg < threshold_reg && job_flag_reg) ?
                                prod_reg[63:16] : '0;
                end
                OP_MIX_LO: acc_reg <= prod_reg;
                OP_MIX_HI: begin
                    // product carries the factor two: take bits 62..15, saturate above
                    if (hi_sum[PROD_W:31] != '0) begin
                        mixed_reg <= MAX48;
                    end else begin
                        mixed_reg <= {hi_sum[30:0], acc_reg[31:15]};
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= M_TDATA_W'({cont_reg, disc_reg, mixed_reg, pair_reg,
                                       prodp_reg, diff_reg, job_above_reg,
                                       approx_reg, job_idx_reg});
            m_tlast_reg <= job_last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    `HRP_ASSERT(a_idle_no_post, s_tready |-> !post_vld_reg, "post step active while idle")
    `HRP_ASSERT_NEXT(a_close_starts, s_accept && close_info.close,
                     (state_reg == ST_RUN) && (op_reg == OP_SUM_LO),
                     "closing request did not start the sequence")
    `HRP_ASSERT_NEXT(a_load_shows, out_load, m_tvalid && s_tready,
                     "result load did not show a result")

endmodule
